/* rtl/core/fbpr_pkg.sv */
package fbpr_pkg;

  // fixed field widths
  localparam int DEST_W     = 32;
  localparam int ID_W       = 24;
  localparam int PIDX_W     = 4;
  localparam int OPORT_W    = 9;
  localparam int ERR_W      = 2;
  localparam int RADIX_W    = 9;
  localparam int DCNT_W     = 4;
  localparam int PCNT_W     = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int LEN_W      = 6;

  // converter run lengths (source bits, MSB first)
  localparam logic [LEN_W-1:0] LEN_ID   = 6'd24;
  localparam logic [LEN_W-1:0] LEN_DEST = 6'd32;

  // item function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ROUTE = 1'b1;

  // route error codes
  localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_NO_PORT = 2'd2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PORTS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_ID = 2'd3;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } conv_ctl_t;

  typedef struct packed {
    logic busy;
    logic ovf;
  } conv_st_t;

endpackage

/* rtl/core/fbpr_digit_conv.sv */
// Binary to radix-k digit converter. Shifts the source in MSB first and
// doubles the whole digit vector each cycle (digit-wise carry ripple).
module fbpr_digit_conv
  import fbpr_pkg::*;
#(
  parameter int MAX_DIGITS = 8,
  parameter int DIGIT_BITS = 8,
  localparam int NW = $clog2(MAX_DIGITS + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  conv_ctl_t                              ctl,
  input  logic [DEST_W-1:0]                      src,
  input  logic [DIGIT_BITS:0]                    radix,
  input  logic [NW-1:0]                          ndig,
  output conv_st_t                               st,
  output logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0]  digits
);

  logic [DEST_W-1:0]                     sh_r;
  logic [LEN_W-1:0]                      cnt_r;
  logic                                  busy_r;
  logic                                  ovf_r;
  logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] dig_r;
  logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] dig_nxt;
  logic                                  ovf_step;

  always_comb begin
    logic                carry;
    logic [DIGIT_BITS:0] t;
    logic [DIGIT_BITS:0] t_sub;
    carry    = sh_r[DEST_W-1];
    ovf_step = 1'b0;
    dig_nxt  = dig_r;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      t     = {dig_r[i], carry};
      t_sub = t - radix;
      if (i < int'(ndig)) begin
        if (t >= radix) begin
          dig_nxt[i] = t_sub[DIGIT_BITS-1:0];
          carry      = 1'b1;
        end else begin
          dig_nxt[i] = t[DIGIT_BITS-1:0];
          carry      = 1'b0;
        end
        // carry out of the top digit: value no longer fits
        if (i == int'(ndig) - 1) ovf_step = carry;
      end else begin
        dig_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ctl.start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == LEN_W'(1)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sh_r  <= src;
      cnt_r <= ctl.len;
      dig_r <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      sh_r  <= sh_r << 1;
      cnt_r <= cnt_r - LEN_W'(1);
      dig_r <= dig_nxt;
      ovf_r <= ovf_r | ovf_step;
    end
  end

  assign st.busy = busy_r;
  assign st.ovf  = ovf_r;
  assign digits  = dig_r;

endmodule

/* rtl/core/flat_butterfly_port_router_core.sv */
// Channel  Direction  Handshake           Payload
// in_      in         in_valid/in_stall   func, dest_endpoint, port_index,
//                                         neighbor_id, neighbor_connected
// out_     out        out_valid/out_stall out_port, local_delivery, route_error
// cfg_     in         cfg_wr_en           cfg_index, cfg_wdata
//
// One item at a time; in_stall is high while the sequencer is busy: an item is in
// the digit converter or the port scan, or its result waits to enter the output
// register. The converter takes one source bit per cycle. Load item: 24-bit
// neighbor id through the converter, then one row write. Route item: 32-bit
// destination through the converter, then a router port scan unless local or
// out of range; the first route after reset or after any register write first
// rebuilds the own digits. Reset is synchronous, active low, and clears the
// connected bits at once. A finished result waits in the output register while
// the next item is accepted; a second result then holds until out_stall drops.
module flat_butterfly_port_router_core
  import fbpr_pkg::*;
#(
  parameter int MAX_ROUTER_PORTS = 16,
  parameter int MAX_DIGITS       = 8,
  parameter int DIGIT_BITS       = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // item input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [DEST_W-1:0]     in_dest_endpoint,
  input  logic [PIDX_W-1:0]     in_port_index,
  input  logic [ID_W-1:0]       in_neighbor_id,
  input  logic                  in_neighbor_connected,
  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OPORT_W-1:0]    out_port,
  output logic                  out_local_delivery,
  output logic [ERR_W-1:0]      out_route_error,
  // config writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PIW  = (MAX_ROUTER_PORTS > 1) ? $clog2(MAX_ROUTER_PORTS) : 1;
  localparam int PCW  = $clog2(MAX_ROUTER_PORTS + 1);
  localparam int NW   = $clog2(MAX_DIGITS + 1);
  localparam int DW   = NW;
  localparam int EW   = (DIGIT_BITS + 1 > RADIX_W) ? DIGIT_BITS + 1 : RADIX_W;
  localparam int SUMW = ((PCW > DIGIT_BITS) ? PCW : DIGIT_BITS) + 1;

  localparam logic [EW-1:0] RADIX_MIN = EW'(2);
  localparam logic [EW-1:0] RADIX_TOP = EW'(1) << DIGIT_BITS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OWN  = 3'd1;  // rebuild own digits
  localparam logic [2:0] S_CONV = 3'd2;  // convert dest or neighbor id
  localparam logic [2:0] S_SCAN = 3'd3;  // min-distance port scan
  localparam logic [2:0] S_FIN  = 3'd4;  // hand result to output reg

  typedef logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] digvec_t;

  // ---------------------------------------------------------------- config
  logic [RADIX_W-1:0] radix_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [PCNT_W-1:0]  pcnt_r;
  logic [ID_W-1:0]    own_id_r;
  logic               own_stale_r;
  logic               own_clr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r     <= RADIX_W'(2);
      dcnt_r      <= DCNT_W'(2);
      pcnt_r      <= '0;
      own_id_r    <= '0;
      own_stale_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RADIX:  radix_r  <= cfg_wdata[RADIX_W-1:0];
          REG_DIGITS: dcnt_r   <= cfg_wdata[DCNT_W-1:0];
          REG_PORTS:  pcnt_r   <= cfg_wdata[PCNT_W-1:0];
          REG_OWN_ID: own_id_r <= cfg_wdata[ID_W-1:0];
          default: ;
        endcase
        own_stale_r <= 1'b1;
      end else if (own_clr) begin
        own_stale_r <= 1'b0;
      end
    end
  end

  // clamped register values
  logic [EW-1:0]       radix_x;
  logic [EW-1:0]       radix_clamp;
  logic [DIGIT_BITS:0] radix_eff;
  logic [NW-1:0]       ndig_eff;
  logic [PCW-1:0]      ports_eff;

  assign radix_x     = EW'(radix_r);
  assign radix_clamp = (radix_x < RADIX_MIN) ? RADIX_MIN :
                       (radix_x > RADIX_TOP) ? RADIX_TOP : radix_x;
  assign radix_eff   = radix_clamp[DIGIT_BITS:0];

  always_comb begin
    if (dcnt_r == '0) begin
      ndig_eff = NW'(1);
    end else if (int'(dcnt_r) > MAX_DIGITS) begin
      ndig_eff = NW'(MAX_DIGITS);
    end else begin
      ndig_eff = NW'(dcnt_r);
    end
  end

  assign ports_eff = (int'(pcnt_r) > MAX_ROUTER_PORTS) ? PCW'(MAX_ROUTER_PORTS)
                                                       : PCW'(pcnt_r);

  // ------------------------------------------------------------- converter
  conv_ctl_t         conv_ctl;
  conv_st_t          conv_st;
  logic [DEST_W-1:0] conv_src;
  digvec_t           conv_dig;
  digvec_t           conv_shift;

  fbpr_digit_conv #(
    .MAX_DIGITS (MAX_DIGITS),
    .DIGIT_BITS (DIGIT_BITS)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (conv_ctl),
    .src    (conv_src),
    .radix  (radix_eff),
    .ndig   (ndig_eff),
    .st     (conv_st),
    .digits (conv_dig)
  );

  // digits of (id * radix): id digits moved up one place, low n kept
  always_comb begin
    conv_shift    = '0;
    for (int j = 1; j < MAX_DIGITS; j++) begin
      if (j < int'(ndig_eff)) conv_shift[j] = conv_dig[j-1];
    end
  end

  // --------------------------------------------------------- neighbor table
  digvec_t                     nbr_mem [MAX_ROUTER_PORTS];
  digvec_t                     rdata_r;
  logic [MAX_ROUTER_PORTS-1:0] nvalid_r;
  logic                        mem_we;
  logic                        rd_en;
  logic [PIW-1:0]              rd_addr;
  logic [PIW-1:0]              ld_port_r, ld_port_nxt;
  logic                        ld_conn_r, ld_conn_nxt;

  always_ff @(posedge clk) begin
    if (mem_we) nbr_mem[ld_port_r] <= conv_shift;
    if (rd_en) rdata_r <= nbr_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nvalid_r <= '0;
    end else if (mem_we) begin
      nvalid_r[ld_port_r] <= ld_conn_r;
    end
  end

  // ---------------------------------------------------------- compare logic
  digvec_t            own_dig_r, own_dig_nxt;
  logic               loc_mis;
  logic [DW-1:0]      ev_dist;
  logic [SUMW-1:0]    loc_sum;

  // destination differs from own router in some upper digit
  always_comb begin
    loc_mis = 1'b0;
    for (int j = 1; j < MAX_DIGITS; j++) begin
      if (j < int'(ndig_eff) && conv_dig[j] != own_dig_r[j]) loc_mis = 1'b1;
    end
  end

  // upper-digit distance to the neighbor row being evaluated
  always_comb begin
    ev_dist = '0;
    for (int j = 1; j < MAX_DIGITS; j++) begin
      if (j < int'(ndig_eff) && conv_dig[j] != rdata_r[j]) ev_dist = ev_dist + DW'(1);
    end
  end

  assign loc_sum = SUMW'(ports_eff) + SUMW'(conv_dig[0]);

  // ------------------------------------------------------------- sequencer
  logic [2:0]         state_r, state_nxt;
  logic               func_r, func_nxt;
  logic [DEST_W-1:0]  item_r, item_nxt;
  logic [PCW-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic               ev_on_r, ev_on_nxt;
  logic [PIW-1:0]     ev_idx_r, ev_idx_nxt;
  logic               found_r, found_nxt;
  logic [PIW-1:0]     best_port_r, best_port_nxt;
  logic [DW-1:0]      best_dist_r, best_dist_nxt;
  logic [OPORT_W-1:0] res_port_r, res_port_nxt;
  logic               res_local_r, res_local_nxt;
  logic [ERR_W-1:0]   res_err_r, res_err_nxt;
  logic               out_load;
  logic               in_acc;
  logic               ld_in_range;
  logic               issue;

  assign in_stall    = (state_r != S_IDLE);
  assign in_acc      = in_valid && !in_stall;
  assign ld_in_range = int'(in_port_index) < MAX_ROUTER_PORTS;
  assign issue       = (scan_cnt_r < ports_eff);
  assign rd_addr     = scan_cnt_r[PIW-1:0];

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    item_nxt      = item_r;
    ld_port_nxt   = ld_port_r;
    ld_conn_nxt   = ld_conn_r;
    scan_cnt_nxt  = scan_cnt_r;
    ev_on_nxt     = ev_on_r;
    ev_idx_nxt    = ev_idx_r;
    found_nxt     = found_r;
    best_port_nxt = best_port_r;
    best_dist_nxt = best_dist_r;
    res_port_nxt  = res_port_r;
    res_local_nxt = res_local_r;
    res_err_nxt   = res_err_r;
    own_dig_nxt   = own_dig_r;
    own_clr       = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    out_load      = 1'b0;
    conv_ctl      = '{start: 1'b0, len: LEN_DEST};
    conv_src      = item_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          func_nxt    = in_func;
          item_nxt    = in_dest_endpoint;
          ld_port_nxt = PIW'(in_port_index);
          ld_conn_nxt = in_neighbor_connected;
          if (in_func == FUNC_ROUTE) begin
            if (own_stale_r) begin
              conv_ctl  = '{start: 1'b1, len: LEN_ID};
              conv_src  = {own_id_r, (DEST_W-ID_W)'(0)};
              state_nxt = S_OWN;
            end else begin
              conv_ctl  = '{start: 1'b1, len: LEN_DEST};
              conv_src  = in_dest_endpoint;
              state_nxt = S_CONV;
            end
          end else if (ld_in_range) begin
            conv_ctl  = '{start: 1'b1, len: LEN_ID};
            conv_src  = {in_neighbor_id, (DEST_W-ID_W)'(0)};
            state_nxt = S_CONV;
          end
          // load to a port beyond the table: dropped
        end
      end

      S_OWN: begin
        if (!conv_st.busy) begin
          own_dig_nxt = conv_shift;
          own_clr     = 1'b1;
          conv_ctl    = '{start: 1'b1, len: LEN_DEST};
          conv_src    = item_r;
          state_nxt   = S_CONV;
        end
      end

      S_CONV: begin
        if (!conv_st.busy) begin
          if (func_r == FUNC_LOAD) begin
            mem_we    = 1'b1;
            state_nxt = S_IDLE;
          end else if (conv_st.ovf) begin
            res_port_nxt  = '0;
            res_local_nxt = 1'b0;
            res_err_nxt   = ERR_RANGE;
            state_nxt     = S_FIN;
          end else if (!loc_mis) begin
            res_port_nxt  = OPORT_W'(loc_sum);
            res_local_nxt = 1'b1;
            res_err_nxt   = ERR_NONE;
            state_nxt     = S_FIN;
          end else begin
            scan_cnt_nxt = '0;
            ev_on_nxt    = 1'b0;
            found_nxt    = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // read stage: one table row per cycle
        if (issue) begin
          rd_en        = 1'b1;
          ev_on_nxt    = 1'b1;
          ev_idx_nxt   = scan_cnt_r[PIW-1:0];
          scan_cnt_nxt = scan_cnt_r + PCW'(1);
        end else begin
          ev_on_nxt = 1'b0;
        end
        // compare stage: <= so the highest index wins a tie
        if (ev_on_r && nvalid_r[ev_idx_r] && (!found_r || ev_dist <= best_dist_r)) begin
          found_nxt     = 1'b1;
          best_dist_nxt = ev_dist;
          best_port_nxt = ev_idx_r;
        end
        if (!issue && !ev_on_r) begin
          res_local_nxt = 1'b0;
          if (found_r) begin
            res_port_nxt = OPORT_W'(best_port_r);
            res_err_nxt  = ERR_NONE;
          end else begin
            res_port_nxt = '0;
            res_err_nxt  = ERR_NO_PORT;
          end
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ev_on_r <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ev_on_r <= ev_on_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    item_r      <= item_nxt;
    ld_port_r   <= ld_port_nxt;
    ld_conn_r   <= ld_conn_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    ev_idx_r    <= ev_idx_nxt;
    best_port_r <= best_port_nxt;
    best_dist_r <= best_dist_nxt;
    res_port_r  <= res_port_nxt;
    res_local_r <= res_local_nxt;
    res_err_r   <= res_err_nxt;
    own_dig_r   <= own_dig_nxt;
  end

  // ------------------------------------------------------- output register
  logic               out_valid_r;
  logic [OPORT_W-1:0] out_port_r;
  logic               out_local_r;
  logic [ERR_W-1:0]   out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_port_r  <= res_port_r;
      out_local_r <= res_local_r;
      out_err_r   <= res_err_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_port           = out_port_r;
  assign out_local_delivery = out_local_r;
  assign out_route_error    = out_err_r;

`ifndef ASSERT_OFF
  // error results carry no port and no local flag
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r != ERR_NONE |-> out_port_r == '0 && !out_local_r)
    else $error("error result with nonzero port or local flag");

  // a remote choice is always one of the active router ports
  a_remote_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r == ERR_NONE && !out_local_r
      |-> int'(out_port_r) < int'(ports_eff))
    else $error("remote port beyond router port count");

  // converter is never left running once the sequencer is back at idle
  a_idle_conv: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !conv_st.busy)
    else $error("digit converter busy while idle");
`endif

endmodule

/* verif/flat_butterfly_port_router_checker.sv */
`timescale 1ns / 1ps
module flat_butterfly_port_router_checker
  import fbpr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  in_func,
  input  logic [DEST_W-1:0]     in_dest_endpoint,
  input  logic [PIDX_W-1:0]     in_port_index,
  input  logic [ID_W-1:0]       in_neighbor_id,
  input  logic                  in_neighbor_connected,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [OPORT_W-1:0]    out_port,
  input  logic                  out_local_delivery,
  input  logic [ERR_W-1:0]      out_route_error,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           routes_owed,
  output int unsigned           fail_count
);

  localparam int PORTS_MAX  = 16;
  localparam int DIGITS_MAX = 8;
  localparam int DIGIT_W    = 8;
  localparam int RADIX_TOP  = 1 << DIGIT_W;

  typedef logic [DIGITS_MAX-1:0][DIGIT_W-1:0] digit_vec_t;

  typedef struct packed {
    logic       ovf;
    digit_vec_t d;
  } conv_t;

  typedef struct packed {
    logic [OPORT_W-1:0] port;
    logic               local_hit;
    logic [ERR_W-1:0]   err;
  } route_t;

  logic [RADIX_W-1:0] radix_q;
  logic [DCNT_W-1:0]  digits_q;
  logic [PCNT_W-1:0]  ports_q;
  logic [ID_W-1:0]    own_id_q;

  digit_vec_t nbr_digits [PORTS_MAX];
  logic       nbr_up [PORTS_MAX];
  digit_vec_t own_digits;

  route_t      owed_q [$];
  int unsigned fails;

  function automatic int unsigned radix_eff();
    int unsigned r;
    r = radix_q;
    if (r < 2) r = 2;
    if (r > RADIX_TOP) r = RADIX_TOP;
    return r;
  endfunction

  function automatic int unsigned digits_eff();
    int unsigned n;
    n = digits_q;
    if (n < 1) n = 1;
    if (n > DIGITS_MAX) n = DIGITS_MAX;
    return n;
  endfunction

  function automatic int unsigned ports_eff();
    int unsigned p;
    p = ports_q;
    if (p > PORTS_MAX) p = PORTS_MAX;
    return p;
  endfunction

  // low digit first, digits above the count stay zero; ovf = value left over
  function automatic conv_t to_base(logic [63:0] num);
    conv_t       c;
    int unsigned r;
    int unsigned n;
    r = radix_eff();
    n = digits_eff();
    c = '0;
    for (int i = 0; i < DIGITS_MAX; i++) begin
      if (i < n) begin
        c.d[i] = DIGIT_W'(num % 64'(r));
        num = num / 64'(r);
      end
    end
    c.ovf = (num != 0);
    return c;
  endfunction

  function automatic void refresh_own();
    own_digits = to_base(64'(own_id_q) * 64'(radix_eff())).d;
  endfunction

  function automatic route_t route_of(logic [DEST_W-1:0] dest);
    conv_t       c;
    route_t      r;
    int unsigned n;
    int unsigned np;
    int unsigned miss;
    int unsigned best_miss;
    int unsigned best_port;
    logic        hit;
    logic        found;
    r = '0;
    c = to_base(64'(dest));
    if (c.ovf) begin
      r.err = ERR_RANGE;
      return r;
    end
    n = digits_eff();
    np = ports_eff();
    hit = 1'b1;
    for (int j = 1; j < n; j++)
      if (c.d[j] != own_digits[j]) hit = 1'b0;
    if (hit) begin
      r.port = OPORT_W'(np + c.d[0]);
      r.local_hit = 1'b1;
      return r;
    end
    // fewest differing upper digits; ties go to the higher port
    found = 1'b0;
    best_miss = 0;
    best_port = 0;
    for (int i = 0; i < np; i++) begin
      if (nbr_up[i]) begin
        miss = 0;
        for (int j = 1; j < n; j++)
          if (c.d[j] != nbr_digits[i][j]) miss++;
        if (!found || miss <= best_miss) begin
          found = 1'b1;
          best_miss = miss;
          best_port = i;
        end
      end
    end
    if (!found) r.err = ERR_NO_PORT;
    else r.port = OPORT_W'(best_port);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    route_t want;
    if (!rst_n) begin
      radix_q = 9'd2;
      digits_q = 4'd2;
      ports_q = 5'd0;
      own_id_q = '0;
      for (int i = 0; i < PORTS_MAX; i++) nbr_up[i] = 1'b0;
      owed_q.delete();
      refresh_own();
    end else begin
      // results first: one leaving now cannot belong to an item entering now
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("result with nothing owed: out_port %0d local_delivery %0b route_error %0d",
                 out_port, out_local_delivery, out_route_error);
          fails++;
        end else begin
          want = owed_q.pop_front();
          if (out_port !== want.port) begin
            $error("out_port: expected %0d, got %0d", want.port, out_port);
            fails++;
          end
          if (out_local_delivery !== want.local_hit) begin
            $error("local_delivery: expected %0b, got %0b", want.local_hit, out_local_delivery);
            fails++;
          end
          if (out_route_error !== want.err) begin
            $error("route_error: expected %0d, got %0d", want.err, out_route_error);
            fails++;
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_RADIX:  radix_q = cfg_wdata[RADIX_W-1:0];
          REG_DIGITS: digits_q = cfg_wdata[DCNT_W-1:0];
          REG_PORTS:  ports_q = cfg_wdata[PCNT_W-1:0];
          REG_OWN_ID: own_id_q = cfg_wdata[ID_W-1:0];
          default: ;
        endcase
        refresh_own();
      end
      if (in_valid && !in_stall) begin
        if (in_func == FUNC_ROUTE) begin
          owed_q.push_back(route_of(in_dest_endpoint));
        end else begin
          nbr_up[in_port_index] = in_neighbor_connected;
          nbr_digits[in_port_index] = to_base(64'(in_neighbor_id) * 64'(radix_eff())).d;
        end
      end
    end
    routes_owed <= owed_q.size();
    fail_count <= fails;
  end

endmodule

/* verif/flat_butterfly_port_router_core_test.sv */
`timescale 1ns / 1ps
module flat_butterfly_port_router_core_test;
  import fbpr_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 7;
  // watchdog limit, far above the slowest clean run
  localparam int CYCLE_LIMIT  = 1_000_000;
  // long receiver hold-off: many route items' worth, so the core backs up
  localparam int HOLD_CYCLES  = 400;
  // drain time for a trailing load, or a route after a register write
  localparam int DRAIN_CYCLES = 80;
  localparam int PORT_SLOTS   = 16;

  typedef logic [7:0][7:0] digit_set_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_func;
  logic [DEST_W-1:0]     in_dest_endpoint;
  logic [PIDX_W-1:0]     in_port_index;
  logic [ID_W-1:0]       in_neighbor_id;
  logic                  in_neighbor_connected;
  logic                  out_valid;
  logic                  out_stall;
  logic [OPORT_W-1:0]    out_port;
  logic                  out_local_delivery;
  logic [ERR_W-1:0]      out_route_error;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned routes_owed;
  int unsigned fail_count;

  // Stimulus-side view of the settings, used only to aim destinations
  // at the own router or at loaded neighbors.
  int unsigned     gen_radix;
  int unsigned     gen_digits;
  logic [ID_W-1:0] gen_own;
  logic [ID_W-1:0] nbr_ids [PORT_SLOTS];
  bit              nbr_seen [PORT_SLOTS];

  bit          no_gaps;      // sender runs back to back
  int unsigned hold_req;     // bumped to ask the receiver for a long hold-off
  int unsigned cycle_count;

  flat_butterfly_port_router_core dut (.*);

  flat_butterfly_port_router_checker route_check (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // value -> base-radix digits, low digit first
  function automatic digit_set_t to_set(logic [63:0] v);
    digit_set_t s;
    for (int i = 0; i < 8; i++) begin
      s[i] = 8'(v % 64'(gen_radix));
      v = v / 64'(gen_radix);
    end
    return s;
  endfunction

  function automatic logic [63:0] from_set(digit_set_t s, int unsigned n);
    logic [63:0] v;
    logic [63:0] pw;
    v = '0;
    pw = 64'd1;
    for (int i = 0; i < n; i++) begin
      v = v + 64'(s[i]) * pw;
      pw = pw * 64'(gen_radix);
    end
    return v;
  endfunction

  // Neighbor id: mostly one or two digits away from our own id (the usual
  // butterfly wiring), sometimes a raw 24-bit value.
  function automatic logic [ID_W-1:0] neighbor_pick();
    digit_set_t  s;
    int unsigned span;
    if ($urandom_range(0, 99) < 20) return ID_W'($urandom);
    s = to_set(64'(gen_own));
    span = (gen_digits > 1) ? gen_digits - 1 : 1;
    repeat ($urandom_range(1, 2))
      s[$urandom_range(0, span - 1)] = 8'($urandom_range(0, gen_radix - 1));
    return ID_W'(from_set(s, span));
  endfunction

  // Destination built from the own id or a loaded neighbor's id, with a few
  // upper digits disturbed; a few are raw 32-bit values (mostly out of range).
  function automatic logic [DEST_W-1:0] pick_dest();
    digit_set_t  base_d;
    digit_set_t  d;
    logic [63:0] v;
    int unsigned p;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) return DEST_W'($urandom);
    p = $urandom_range(0, PORT_SLOTS - 1);
    base_d = to_set(64'((pick < 35 || !nbr_seen[p]) ? gen_own : nbr_ids[p]));
    d = '0;
    d[0] = 8'($urandom_range(0, gen_radix - 1));
    for (int i = 1; i < 8; i++) d[i] = base_d[i-1];
    if (gen_digits > 1)
      repeat ($urandom_range(0, 2))
        d[$urandom_range(1, gen_digits - 1)] = 8'($urandom_range(0, gen_radix - 1));
    v = from_set(d, gen_digits);
    if (v > 64'hFFFF_FFFF) v = 64'($urandom);
    return DEST_W'(v);
  endfunction

  // Called at a falling edge. Holds the item until it is taken, then maybe
  // idles the input for a while.
  task automatic drive_item(input logic func, input logic [DEST_W-1:0] dest,
                            input logic [PIDX_W-1:0] pidx, input logic [ID_W-1:0] nid,
                            input logic conn);
    int unsigned pick;
    int unsigned gap;
    in_func = func;
    in_dest_endpoint = dest;
    in_port_index = pidx;
    in_neighbor_id = nid;
    in_neighbor_connected = conn;
    in_valid = 1'b1;
    if (func == FUNC_LOAD) begin
      nbr_ids[pidx] = nid;
      nbr_seen[pidx] = 1'b1;
    end
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
    if (!no_gaps) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 95) gap = $urandom_range(4, 12);
      else gap = $urandom_range(20, 60);
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // unused fields of an item carry random values
  task automatic send_route(input logic [DEST_W-1:0] dest);
    drive_item(FUNC_ROUTE, dest, PIDX_W'($urandom), ID_W'($urandom), 1'($urandom));
  endtask

  task automatic send_load(input logic [PIDX_W-1:0] pidx, input logic [ID_W-1:0] nid,
                           input logic conn);
    drive_item(FUNC_LOAD, DEST_W'($urandom), pidx, nid, conn);
  endtask

  // Wait out every owed result, then give a trailing load time to finish.
  task automatic settle();
    in_valid = 1'b0;
    while (routes_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_wdata = data;
    cfg_wr_en = 1'b1;
    @(negedge clk);
  endtask

  // All four registers, with junk above the radix, digit count and port count fields.
  task automatic program_regs(input logic [RADIX_W-1:0] r, input logic [DCNT_W-1:0] n,
                              input logic [PCNT_W-1:0] p, input logic [ID_W-1:0] own);
    logic [CFG_DATA_W-1:0] junk;
    settle();
    junk = CFG_DATA_W'($urandom);
    write_reg(REG_RADIX, {junk[CFG_DATA_W-1:RADIX_W], r});
    write_reg(REG_DIGITS, {junk[CFG_DATA_W-1:DCNT_W], n});
    write_reg(REG_PORTS, {junk[CFG_DATA_W-1:PCNT_W], p});
    write_reg(REG_OWN_ID, own);
    cfg_wr_en = 1'b0;
    gen_radix = (r < 2) ? 2 : (r > 256) ? 256 : r;
    gen_digits = (n < 1) ? 1 : (n > 8) ? 8 : n;
    gen_own = own;
  endtask

  // One setting: optionally load every port first, then a route-heavy mix.
  task automatic run_phase(input logic [RADIX_W-1:0] r, input logic [DCNT_W-1:0] n,
                           input logic [PCNT_W-1:0] p, input logic [ID_W-1:0] own,
                           input int unsigned count, input bit load_all, input bit hold,
                           input bit burst);
    int unsigned sent;
    program_regs(r, n, p, own);
    no_gaps = burst;
    if (hold) hold_req++;
    sent = 0;
    if (load_all) begin
      for (int i = 0; i < PORT_SLOTS; i++) begin
        send_load(PIDX_W'(i), neighbor_pick(), $urandom_range(0, 99) < 85);
        sent++;
      end
    end
    while (sent < count) begin
      if ($urandom_range(0, 99) < 75) begin
        send_route(pick_dest());
      end else begin
        send_load(PIDX_W'($urandom_range(0, PORT_SLOTS - 1)), neighbor_pick(),
                  $urandom_range(0, 99) < 85);
      end
      sent++;
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: short stall bursts, quiet stretches, the odd long stall, and a
  // long hold-off on request while the sender keeps offering items.
  initial begin : receiver
    int unsigned holds_served;
    int unsigned pick;
    int unsigned run;
    holds_served = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_served) begin
        holds_served = hold_req;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
          out_stall = 1'b0;
          run = $urandom_range(1, 6);
        end else if (pick < 85) begin
          out_stall = 1'b1;
          run = $urandom_range(1, 3);
        end else if (pick < 93) begin
          out_stall = 1'b0;
          run = $urandom_range(50, 150);
        end else begin
          out_stall = 1'b1;
          run = $urandom_range(15, 60);
        end
        repeat (run - 1) @(negedge clk);
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_LOAD;
    in_dest_endpoint = '0;
    in_port_index = '0;
    in_neighbor_id = '0;
    in_neighbor_connected = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_RADIX;
    cfg_wdata = '0;
    no_gaps = 1'b0;
    hold_req = 0;
    gen_radix = 2;
    gen_digits = 2;
    gen_own = '0;
    for (int i = 0; i < PORT_SLOTS; i++) nbr_seen[i] = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed ---
    // Reset values: radix 2, two digits, no router ports, own id 0.
    send_route(32'd0);                   // local port 0
    send_route(32'd1);                   // local port 1
    send_route(32'd2);                   // upper digit differs, no router port
    send_route(32'hFFFF_FFFF);           // too large for two binary digits
    send_load(4'd15, 24'hFF_FFFF, 1'b1); // base overflows, upper digits dropped
    send_load(4'd0, 24'd1, 1'b1);
    send_route(32'd2);                   // entries stored, but port count is zero

    // Radix 0 acts as 2, zero digits as one, 31 ports as 16.
    program_regs(9'd0, 4'd0, 5'd31, 24'hFF_FFFF);
    send_route(32'd1);                   // single digit: always local, port 17
    send_route(32'd2);                   // exceeds the single digit

    // Radix and digit count above range; old entries keep their binary digits.
    program_regs(9'd511, 4'd15, 5'd16, 24'hFF_FFFF);
    send_route(32'hFFFF_FFFF);           // matches own base: highest local port
    send_route(32'd0);                   // stale entries on 0 and 15 tie
    send_load(4'd3, 24'h00_0100, 1'b1);
    send_route(32'h0001_0005);           // exact neighbor match on port 3
    send_load(4'd15, 24'd0, 1'b0);       // disconnect port 15
    send_route(32'd0);                   // tie now settles on port 3

    // --- random, one setting per phase ---
    run_phase(9'd4, 4'd4, 5'd8, ID_W'($urandom_range(0, 63)), 80, 1, 0, 0);
    run_phase(9'd2, 4'd8, 5'd16, ID_W'($urandom_range(0, 127)), 80, 1, 1, 0);
    run_phase(9'd256, 4'd4, 5'd16, ID_W'($urandom), 80, 1, 0, 1);
    run_phase(9'd511, 4'd15, 5'd31, 24'hFF_FFFF, 70, 1, 0, 0);
    // stale entries in the next phases unless reloaded by the mix
    run_phase(9'd0, 4'd0, 5'd5, ID_W'($urandom), 40, 0, 0, 0);
    run_phase(9'd10, 4'd6, 5'd12, ID_W'($urandom_range(0, 99999)), 80, 0, 1, 0);
    run_phase(9'd3, 4'd5, 5'd0, ID_W'($urandom_range(0, 80)), 40, 0, 0, 0);
    run_phase(9'($urandom_range(2, 256)), 4'($urandom_range(1, 8)),
              5'($urandom_range(1, 16)), ID_W'($urandom), 80, 1, 0, 0);
    run_phase(9'd16, 4'd7, 5'd16, ID_W'($urandom_range(0, 16777215)), 80, 1, 1, 0);

    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
